### rtl/lsjd_pkg.sv
// Shared types, codes and helper functions for the line sensor junction detector.
package lsjd_pkg;

   localparam int AGREE_DEPTH = 3;
   localparam int PTR_W       = (AGREE_DEPTH > 1) ? $clog2(AGREE_DEPTH) : 1;

   typedef enum logic [2:0] {
      CLS_MID   = 3'd0,
      CLS_FULL  = 3'd1,
      CLS_RIGHT = 3'd2,
      CLS_LEFT  = 3'd3,
      CLS_EMPTY = 3'd4,
      CLS_TEE   = 3'd5,
      CLS_NONE  = 3'd6
   } cls_type;

   typedef enum logic [3:0] {
      JN_DEAD_END     = 4'd0,
      JN_TEE          = 4'd2,
      JN_TEE_RIGHT    = 4'd3,
      JN_TEE_LEFT     = 4'd4,
      JN_CROSS        = 4'd5,
      JN_START_END    = 4'd6,
      JN_UNKNOWN      = 4'd7,
      JN_RIGHT_CORNER = 4'd8,
      JN_LEFT_CORNER  = 4'd9
   } jn_type;

   typedef enum logic [2:0] {
      REG_PATTERN_MID      = 3'd0,
      REG_PATTERN_FULL     = 3'd1,
      REG_PATTERN_RIGHT    = 3'd2,
      REG_PATTERN_LEFT     = 3'd3,
      REG_PATTERN_EMPTY    = 3'd4,
      REG_PATTERN_TEE_MARK = 3'd5,
      REG_MAX_MISMATCH     = 3'd6
   } reg_index_type;

   localparam logic [7:0] RST_PATTERN_MID      = 8'b0001_1000;
   localparam logic [7:0] RST_PATTERN_FULL     = 8'b1111_1111;
   localparam logic [7:0] RST_PATTERN_RIGHT    = 8'b0001_1111;
   localparam logic [7:0] RST_PATTERN_LEFT     = 8'b1111_1000;
   localparam logic [7:0] RST_PATTERN_EMPTY    = 8'b0000_0000;
   localparam logic [7:0] RST_PATTERN_TEE_MARK = 8'b0110_0110;
   localparam logic [3:0] RST_MAX_MISMATCH     = 4'd1;

   typedef struct packed {
      logic [7:0] pattern_mid;
      logic [7:0] pattern_full;
      logic [7:0] pattern_right;
      logic [7:0] pattern_left;
      logic [7:0] pattern_empty;
      logic [7:0] pattern_tee_mark;
      logic [3:0] max_mismatch;
   } cfg_type;

   typedef struct packed {
      logic   stable;
      jn_type junction;
   } track_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

   function automatic jn_type decode_junction(input cls_type newest, input cls_type prev);
      jn_type j;
      j = JN_UNKNOWN;
      if (newest == CLS_MID && prev == CLS_FULL) begin
         j = JN_CROSS;
      end else if (newest == CLS_EMPTY && prev == CLS_FULL) begin
         j = JN_TEE;
      end else if (newest == CLS_EMPTY && prev == CLS_RIGHT) begin
         j = JN_RIGHT_CORNER;
      end else if (newest == CLS_EMPTY && prev == CLS_LEFT) begin
         j = JN_LEFT_CORNER;
      end else if (newest == CLS_MID && prev == CLS_RIGHT) begin
         j = JN_TEE_RIGHT;
      end else if (newest == CLS_MID && prev == CLS_LEFT) begin
         j = JN_TEE_LEFT;
      end else if (newest == CLS_FULL && prev == CLS_TEE) begin
         j = JN_START_END;
      end else if (newest == CLS_EMPTY && prev == CLS_MID) begin
         j = JN_DEAD_END;
      end
      return j;
   endfunction

endpackage

### rtl/line_sensor_junction_detector_unit.sv
// Top level: config registers, input register, classifier, tracker and result register.
// Takes one sensor word per cycle when the result side keeps up; each accepted word passes
// through the input register, then the result register, before its result can be taken.
// The ring, pointer and history update when a word moves from the input register to the
// result register, so the one-word-per-cycle rate is set by that single classify-and-decode
// path. The user is to write pattern and mismatch registers through the csr port while
// idle; the block itself does not enforce this.
module line_sensor_junction_detector_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_sensor_bits,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_sample_class,
   output logic       rsp_stable,
   output logic [3:0] rsp_junction,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import lsjd_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_bits_ff;
   logic       out_valid_ff;
   logic [2:0] out_class_ff;
   logic       out_stable_ff;
   logic [3:0] out_junction_ff;
   logic       advance;
   cls_type    cls;
   track_type  track;

   // word moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_mid      <= RST_PATTERN_MID;
         cfg_ff.pattern_full     <= RST_PATTERN_FULL;
         cfg_ff.pattern_right    <= RST_PATTERN_RIGHT;
         cfg_ff.pattern_left     <= RST_PATTERN_LEFT;
         cfg_ff.pattern_empty    <= RST_PATTERN_EMPTY;
         cfg_ff.pattern_tee_mark <= RST_PATTERN_TEE_MARK;
         cfg_ff.max_mismatch     <= RST_MAX_MISMATCH;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_PATTERN_MID:      cfg_ff.pattern_mid      <= csr_wdata;
            REG_PATTERN_FULL:     cfg_ff.pattern_full     <= csr_wdata;
            REG_PATTERN_RIGHT:    cfg_ff.pattern_right    <= csr_wdata;
            REG_PATTERN_LEFT:     cfg_ff.pattern_left     <= csr_wdata;
            REG_PATTERN_EMPTY:    cfg_ff.pattern_empty    <= csr_wdata;
            REG_PATTERN_TEE_MARK: cfg_ff.pattern_tee_mark <= csr_wdata;
            REG_MAX_MISMATCH:     cfg_ff.max_mismatch     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_bits_ff <= req_sensor_bits;
      end
   end

   lsjd_classify u_classify (
      .sensor_bits  (in_bits_ff),
      .cfg          (cfg_ff),
      .sample_class (cls)
   );

   lsjd_track u_track (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample_class (cls),
      .track        (track)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_class_ff    <= 3'(cls);
         out_stable_ff   <= track.stable;
         out_junction_ff <= 4'(track.junction);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_class = out_class_ff;
   assign rsp_stable       = out_stable_ff;
   assign rsp_junction     = out_junction_ff;

endmodule

### rtl/lsjd_classify.sv
// Pattern matcher: picks the first pattern within the mismatch limit.
module lsjd_classify (
   input  logic [7:0]       sensor_bits,
   input  lsjd_pkg::cfg_type cfg,
   output lsjd_pkg::cls_type sample_class
);
   import lsjd_pkg::*;

   logic near_empty, near_full, near_right, near_left, near_mid, near_tee;

   assign near_empty = popcount8(sensor_bits ^ cfg.pattern_empty)    <= cfg.max_mismatch;
   assign near_full  = popcount8(sensor_bits ^ cfg.pattern_full)     <= cfg.max_mismatch;
   assign near_right = popcount8(sensor_bits ^ cfg.pattern_right)    <= cfg.max_mismatch;
   assign near_left  = popcount8(sensor_bits ^ cfg.pattern_left)     <= cfg.max_mismatch;
   assign near_mid   = popcount8(sensor_bits ^ cfg.pattern_mid)      <= cfg.max_mismatch;
   assign near_tee   = popcount8(sensor_bits ^ cfg.pattern_tee_mark) <= cfg.max_mismatch;

   always_comb begin
      if (near_empty) begin
         sample_class = CLS_EMPTY;
      end else if (near_full) begin
         sample_class = CLS_FULL;
      end else if (near_right) begin
         sample_class = CLS_RIGHT;
      end else if (near_left) begin
         sample_class = CLS_LEFT;
      end else if (near_mid) begin
         sample_class = CLS_MID;
      end else if (near_tee) begin
         sample_class = CLS_TEE;
      end else begin
         sample_class = CLS_NONE;
      end
   end

endmodule

### rtl/lsjd_track.sv
// Agreement ring and class history with junction decode.
module lsjd_track (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lsjd_pkg::cls_type  sample_class,
   output lsjd_pkg::track_type track
);
   import lsjd_pkg::*;

   cls_type          ring_ff [AGREE_DEPTH];
   cls_type          ring_in [AGREE_DEPTH];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   cls_type          hist0_ff, hist0_in;
   cls_type          hist1_ff, hist1_in;
   logic             agree;

   always_comb begin
      for (int i = 0; i < AGREE_DEPTH; i++) begin
         ring_in[i] = (ptr_ff == PTR_W'(i)) ? sample_class : ring_ff[i];
      end
      agree = 1'b1;
      for (int i = 1; i < AGREE_DEPTH; i++) begin
         if (ring_in[i] != ring_in[0]) begin
            agree = 1'b0;
         end
      end
      ptr_in   = (ptr_ff == PTR_W'(AGREE_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
      hist0_in = agree ? sample_class : hist0_ff;
      hist1_in = agree ? hist0_ff : hist1_ff;
      // all entries equal the new class when agreed, so decode off it directly
      track.stable   = agree;
      track.junction = agree ? decode_junction(sample_class, hist0_ff) : JN_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AGREE_DEPTH; i++) begin
            ring_ff[i] <= CLS_NONE;
         end
         ptr_ff   <= '0;
         hist0_ff <= CLS_NONE;
         hist1_ff <= CLS_NONE;
      end else if (advance) begin
         ring_ff  <= ring_in;
         ptr_ff   <= ptr_in;
         hist0_ff <= hist0_in;
         hist1_ff <= hist1_in;
      end
   end

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(AGREE_DEPTH - 1))
      else $error("ring pointer out of range");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ptr_ff) && $stable(hist0_ff) && $stable(hist1_ff))
      else $error("tracking state moved without a word");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      advance && track.stable |=> hist0_ff == $past(sample_class)
                                  && hist1_ff == $past(hist0_ff))
      else $error("history did not shift on agreement");

   a_junction_needs_stable: assert property (@(posedge clock) disable iff (reset)
      !track.stable |-> track.junction == JN_UNKNOWN)
      else $error("junction decoded without agreement");

endmodule

### test/line_sensor_junction_detector_unit_tb.sv
// Self-checking testbench for the line sensor junction detector: directed and random samples.
`timescale 1ns / 1ps

module line_sensor_junction_detector_unit_tb;
   import lsjd_pkg::*;

   localparam logic [2:0] CSR_UNMAPPED   = 3'd7;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         RANDOM_PHASES  = 10;
   localparam int         PHASE_WORDS    = 150;

   typedef struct packed {
      cls_type cls;
      logic    stable;
      jn_type  jn;
   } class_report_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_sensor_bits = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [2:0] rsp_sample_class;
   logic       rsp_stable;
   logic [3:0] rsp_junction;
   logic       csr_we          = 1'b0;
   logic [2:0] csr_index       = 3'd0;
   logic [7:0] csr_wdata       = 8'h00;

   // shadow of the block's registers and tracking state
   logic [7:0]    sensor_pat [0:5];
   logic [3:0]    mismatch_limit;
   cls_type       agree_ring [0:AGREE_DEPTH-1];
   int            ring_ptr;
   cls_type       hist_newest;
   cls_type       hist_prev;

   class_report_type pending_reports [$];
   bit            idle_on    = 1'b1;
   int            fail_count = 0;
   int            rsp_hold_left = 0;
   int            quiet_cycles  = 0;

   line_sensor_junction_detector_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sensor_bits  (req_sensor_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_class (rsp_sample_class),
      .rsp_stable       (rsp_stable),
      .rsp_junction     (rsp_junction),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic bit near(input logic [7:0] bits, input logic [7:0] pat);
      return $countones(bits ^ pat) <= mismatch_limit;
   endfunction

   function automatic cls_type classify_bits(input logic [7:0] bits);
      if (near(bits, sensor_pat[REG_PATTERN_EMPTY]))    return CLS_EMPTY;
      if (near(bits, sensor_pat[REG_PATTERN_FULL]))     return CLS_FULL;
      if (near(bits, sensor_pat[REG_PATTERN_RIGHT]))    return CLS_RIGHT;
      if (near(bits, sensor_pat[REG_PATTERN_LEFT]))     return CLS_LEFT;
      if (near(bits, sensor_pat[REG_PATTERN_MID]))      return CLS_MID;
      if (near(bits, sensor_pat[REG_PATTERN_TEE_MARK])) return CLS_TEE;
      return CLS_NONE;
   endfunction

   function automatic jn_type junction_of(input cls_type newest, input cls_type prev);
      case (newest)
         CLS_MID: begin
            if (prev == CLS_FULL)  return JN_CROSS;
            if (prev == CLS_RIGHT) return JN_TEE_RIGHT;
            if (prev == CLS_LEFT)  return JN_TEE_LEFT;
         end
         CLS_EMPTY: begin
            if (prev == CLS_FULL)  return JN_TEE;
            if (prev == CLS_RIGHT) return JN_RIGHT_CORNER;
            if (prev == CLS_LEFT)  return JN_LEFT_CORNER;
            if (prev == CLS_MID)   return JN_DEAD_END;
         end
         CLS_FULL: begin
            if (prev == CLS_TEE)   return JN_START_END;
         end
         default: ;
      endcase
      return JN_UNKNOWN;
   endfunction

   function automatic class_report_type track_sample(input logic [7:0] bits);
      class_report_type r;
      cls_type       c;
      logic          agree;
      c = classify_bits(bits);
      agree_ring[ring_ptr] = c;
      ring_ptr = (ring_ptr == AGREE_DEPTH - 1) ? 0 : ring_ptr + 1;
      agree = 1'b1;
      for (int i = 1; i < AGREE_DEPTH; i++) begin
         if (agree_ring[i] != agree_ring[0]) agree = 1'b0;
      end
      r.cls    = c;
      r.stable = agree;
      r.jn     = JN_UNKNOWN;
      if (agree) begin
         hist_prev   = hist_newest;
         hist_newest = agree_ring[0];
         r.jn        = junction_of(hist_newest, hist_prev);
      end
      return r;
   endfunction

   task automatic reset_shadow();
      sensor_pat[REG_PATTERN_MID]      = 8'h18;
      sensor_pat[REG_PATTERN_FULL]     = 8'hFF;
      sensor_pat[REG_PATTERN_RIGHT]    = 8'h1F;
      sensor_pat[REG_PATTERN_LEFT]     = 8'hF8;
      sensor_pat[REG_PATTERN_EMPTY]    = 8'h00;
      sensor_pat[REG_PATTERN_TEE_MARK] = 8'h66;
      mismatch_limit = 4'd1;
      for (int i = 0; i < AGREE_DEPTH; i++) agree_ring[i] = CLS_NONE;
      ring_ptr    = 0;
      hist_newest = CLS_NONE;
      hist_prev   = CLS_NONE;
   endtask

   // one sensor word through the request handshake, with an optional gap first
   task automatic send_word(input logic [7:0] bits);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sensor_bits <= bits;
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(track_sample(bits));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_MAX_MISMATCH) mismatch_limit = data[3:0];
      else if (idx <= REG_PATTERN_TEE_MARK) sensor_pat[idx] = data;
   endtask

   // reset patterns, most held three words each so the ring agrees and junctions decode
   task automatic test_reset_patterns();
      logic [7:0] words [$] = '{8'h00, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'h18, 8'h18, 8'h18,
                                8'h66, 8'h66, 8'h66, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                8'h00, 8'h1F, 8'h1F, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h19,
                                8'h7E};
      foreach (words[i]) send_word(words[i]);
      wait_idle();
   endtask

   task automatic test_mismatch_limits();
      write_reg(REG_MAX_MISMATCH, 8'h00);
      foreach (sensor_pat[i]) send_word(sensor_pat[i]);
      send_word(8'h19);
      send_word(8'h01);
      wait_idle();
      write_reg(REG_MAX_MISMATCH, 8'h02);
      send_word(8'h1B);
      send_word(8'hE7);
      wait_idle();
      // eight or more: everything lands on the empty pattern
      write_reg(REG_MAX_MISMATCH, 8'h08);
      repeat (3) send_word(8'h5A);
      send_word(8'hFF);
      wait_idle();
      write_reg(REG_MAX_MISMATCH, 8'h0F);
      repeat (3) send_word(8'hC3);
      wait_idle();
      write_reg(REG_MAX_MISMATCH, 8'h01);
   endtask

   task automatic test_unmapped_index();
      write_reg(CSR_UNMAPPED, 8'hFF);
      repeat (3) send_word(8'h18);
      repeat (3) send_word(8'h00);
      wait_idle();
   endtask

   task automatic program_phase(input int phase);
      logic [3:0] mm;
      for (int r = REG_PATTERN_MID; r <= REG_PATTERN_TEE_MARK; r++) begin
         case (phase)
            0:       write_reg(r[2:0], 8'h00);
            1:       write_reg(r[2:0], 8'hFF);
            2:       write_reg(r[2:0], sensor_pat[r]);
            default: write_reg(r[2:0], 8'($urandom_range(0, 255)));
         endcase
      end
      case (phase)
         0:       mm = 4'd0;
         1:       mm = 4'd8;
         2:       mm = 4'd0;
         3:       mm = 4'd15;
         default: mm = 4'($urandom_range(0, 3));
      endcase
      // upper data bits are don't-care for the mismatch register
      write_reg(REG_MAX_MISMATCH, {4'($urandom_range(0, 15)), mm});
   endtask

   task automatic test_random_phases();
      int         sent;
      int         run_len;
      int         target;
      logic [7:0] flips;
      logic [7:0] bits;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         program_phase(phase);
         idle_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if ($urandom_range(0, 6) == 0) begin
               send_word(8'($urandom_range(0, 255)));
               sent++;
            end else begin
               target  = $urandom_range(0, 5);
               run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(3, 5);
               for (int k = 0; k < run_len; k++) begin
                  flips = 8'h00;
                  repeat ($urandom_range(0, 2)) flips[$urandom_range(0, 7)] = 1'b1;
                  bits = sensor_pat[target] ^ flips;
                  send_word(bits);
                  sent++;
               end
            end
         end
      end
   endtask

   // response side: scoreboard check plus random backpressure
   always @(posedge clock) begin
      class_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("result word with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_sample_class !== want.cls) begin
               $error("sample_class expected %0d got %0d", want.cls, rsp_sample_class);
               fail_count++;
            end
            if (rsp_stable !== want.stable) begin
               $error("stable expected %0d got %0d", want.stable, rsp_stable);
               fail_count++;
            end
            if (rsp_junction !== want.jn) begin
               $error("junction expected %0d got %0d", want.jn, rsp_junction);
               fail_count++;
            end
         end
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         rsp_hold_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_patterns();
      test_mismatch_limits();
      test_unmapped_index();
      test_random_phases();
      idle_on = 1'b0;
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
